// ===== rtl/bse_pkg.sv =====
// Shared constants, types and helpers for the bitmap set engine.
package bse_pkg;

  localparam int WORDS     = 16;
  localparam int WORD_BITS = 64;
  localparam int ADDR_W    = $clog2(WORDS);
  localparam int CNT_W     = $clog2(WORDS + 1);
  localparam int OFS_W     = $clog2(WORD_BITS);
  localparam int BIT_W     = 10;
  localparam int BW_W      = BIT_W - OFS_W;
  localparam int FIRST_W   = 11;

  typedef enum logic [2:0] {
    FN_SET        = 3'd0,
    FN_TEST       = 3'd1,
    FN_CLEAR_ALL  = 3'd2,
    FN_EMPTY      = 3'd3,
    FN_OR_WORD    = 3'd4,
    FN_AND_WORD   = 3'd5,
    FN_FIRST_SET  = 3'd6,
    FN_SINGLE_BIT = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  // Request bundle from the sequencer to the word store.
  typedef struct packed {
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORDS-1:0]     clr_mask;
  } store_req_t;

  // Position of the lowest set bit; 0 for an all-zero word.
  function automatic logic [OFS_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
    logic [OFS_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = OFS_W'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/bse_store.sv =====
// Word store: synchronous memory with per-word valid bits for clearing words at once.
module bse_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bse_pkg::store_req_t           req,
  output logic [bse_pkg::WORD_BITS-1:0] rd_data
);
  import bse_pkg::*;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WORDS-1:0]     valid_r;
  logic [WORDS-1:0]     valid_nxt;

  always_comb begin
    valid_nxt = valid_r & ~req.clr_mask;
    if (req.wr_en) begin
      valid_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
    rd_vld_r  <= valid_r[req.rd_addr];
  end

  // A word never written since its last clear reads as zero.
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/bitmap_set_engine.sv =====
// Top level of the bitmap set engine: command sequencer around the word store.
// Sequencing: clear_all, empty, out-of-range and trivially answered commands give their
//   result beat in the cycle after start; set, test, or_word and and_word pass through
//   ST_READ and ST_EVAL; first_set and single_bit repeat both per in-use word scanned.
// Throughput: one command at a time; busy stays high until the result beat is issued.
// Each read-evaluate step of the single store port goes through ST_READ, then ST_EVAL.
// Reset clears the in-use count and all word valid bits at once: no clearing pass.
// The result beat lasts exactly one cycle; the receiver cannot stall it.
module bitmap_set_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_func,
  input  logic [bse_pkg::BIT_W-1:0]     in_bit_index,
  input  logic [bse_pkg::ADDR_W-1:0]    in_word_index,
  input  logic [bse_pkg::WORD_BITS-1:0] in_word_value,
  input  logic                          in_last_word,
  output logic                          out_valid,
  output logic                          out_answer,
  output logic [bse_pkg::FIRST_W-1:0]   out_first_set,
  output logic [bse_pkg::CNT_W-1:0]     out_words_in_use,
  output logic                          out_out_of_range
);
  import bse_pkg::*;

  // Sequencer state and latched command.
  state_t               state_r, state_nxt;
  func_t                func_r, func_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [ADDR_W-1:0]    widx_r, widx_nxt;
  logic [WORD_BITS-1:0] wval_r, wval_nxt;
  logic [ADDR_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  // Result beat registers.
  logic                 out_valid_r, out_valid_nxt;
  logic                 answer_r, answer_nxt;
  logic [FIRST_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]     words_r, words_nxt;
  logic                 oor_r, oor_nxt;

  store_req_t           req;
  logic [WORD_BITS-1:0] word;

  // Decoded views of the command.
  logic [BW_W-1:0]      in_bw;
  logic [BW_W-1:0]      cur_bw;
  logic [WORD_BITS-1:0] cur_mask;
  logic                 last_scan;

  logic                 finish;
  logic                 ans;
  logic [FIRST_W-1:0]   fst;
  logic                 oor;

  bse_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (word)
  );

  assign in_bw     = in_bit_index[BIT_W-1:OFS_W];
  assign cur_bw    = bit_r[BIT_W-1:OFS_W];
  assign cur_mask  = WORD_BITS'(1) << bit_r[OFS_W-1:0];
  assign last_scan = (CNT_W'(idx_r) + CNT_W'(1)) >= count_r;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    bit_nxt       = bit_r;
    widx_nxt      = widx_r;
    wval_nxt      = wval_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    answer_nxt    = answer_r;
    first_nxt     = first_r;
    words_nxt     = words_r;
    oor_nxt       = oor_r;
    finish        = 1'b0;
    ans           = 1'b0;
    fst           = '0;
    oor           = 1'b0;
    req.rd_addr   = idx_r;
    req.wr_en     = 1'b0;
    req.wr_addr   = idx_r;
    req.wr_data   = word;
    req.clr_mask  = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Latch the command beat.
          func_nxt = func_t'(in_func);
          bit_nxt  = in_bit_index;
          widx_nxt = in_word_index;
          wval_nxt = in_word_value;
          case (func_t'(in_func))
            FN_SET, FN_TEST: begin
              if (CNT_W'(in_bw) >= CNT_W'(WORDS)) begin
                oor    = 1'b1;
                finish = 1'b1;
              end else if (func_t'(in_func) == FN_TEST && CNT_W'(in_bw) >= count_r) begin
                // Bit lies outside the in-use words: answer is zero.
                finish = 1'b1;
              end else begin
                idx_nxt   = ADDR_W'(in_bw);
                state_nxt = ST_READ;
              end
            end
            FN_CLEAR_ALL: begin
              req.clr_mask = '1;
              finish       = 1'b1;
            end
            FN_EMPTY: begin
              req.clr_mask = '1;
              count_nxt    = '0;
              finish       = 1'b1;
            end
            FN_OR_WORD: begin
              if (CNT_W'(in_word_index) >= CNT_W'(WORDS)) begin
                oor    = 1'b1;
                finish = 1'b1;
              end else begin
                idx_nxt   = in_word_index;
                state_nxt = ST_READ;
              end
            end
            FN_AND_WORD: begin
              if (CNT_W'(in_word_index) >= CNT_W'(WORDS)) begin
                oor    = 1'b1;
                finish = 1'b1;
              end else begin
                // Trim every word above the final source word; those past the
                // count are zero already, so dropping them all is equivalent.
                if (in_last_word) begin
                  for (int i = 0; i < WORDS; i++) begin
                    req.clr_mask[i] = (i > int'(in_word_index));
                  end
                end
                if (CNT_W'(in_word_index) >= count_r) begin
                  finish = 1'b1;
                end else begin
                  idx_nxt   = in_word_index;
                  state_nxt = ST_READ;
                end
              end
            end
            FN_FIRST_SET: begin
              if (count_r == '0) begin
                finish = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            FN_SINGLE_BIT: begin
              if (CNT_W'(in_bw) >= CNT_W'(WORDS)) begin
                oor    = 1'b1;
                finish = 1'b1;
              end else if (CNT_W'(in_bw) >= count_r) begin
                finish = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = ST_READ;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        // Store read issued at idx_r; data arrives next cycle.
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        case (func_r)
          FN_SET: begin
            req.wr_en   = 1'b1;
            req.wr_data = word | cur_mask;
            if (CNT_W'(cur_bw) >= count_r) begin
              count_nxt = CNT_W'(cur_bw) + CNT_W'(1);
            end
            finish = 1'b1;
          end
          FN_TEST: begin
            ans    = |(word & cur_mask);
            finish = 1'b1;
          end
          FN_OR_WORD: begin
            req.wr_en   = 1'b1;
            req.wr_data = word | wval_r;
            if (CNT_W'(widx_r) >= count_r) begin
              count_nxt = CNT_W'(widx_r) + CNT_W'(1);
            end
            finish = 1'b1;
          end
          FN_AND_WORD: begin
            req.wr_en   = 1'b1;
            req.wr_data = word & wval_r;
            finish      = 1'b1;
          end
          FN_FIRST_SET: begin
            if (word != '0) begin
              fst    = FIRST_W'({idx_r, lowest_bit(word)}) + FIRST_W'(1);
              finish = 1'b1;
            end else if (last_scan) begin
              finish = 1'b1;
            end else begin
              idx_nxt   = idx_r + ADDR_W'(1);
              state_nxt = ST_READ;
            end
          end
          FN_SINGLE_BIT: begin
            // The target word must hold exactly the bit; every other word is zero.
            if ((idx_r == ADDR_W'(cur_bw)) ? (word != cur_mask) : (word != '0)) begin
              finish = 1'b1;
            end else if (last_scan) begin
              ans    = 1'b1;
              finish = 1'b1;
            end else begin
              idx_nxt   = idx_r + ADDR_W'(1);
              state_nxt = ST_READ;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      answer_nxt    = ans;
      first_nxt     = fst;
      words_nxt     = count_nxt;
      oor_nxt       = oor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    bit_r    <= bit_nxt;
    widx_r   <= widx_nxt;
    wval_r   <= wval_nxt;
    idx_r    <= idx_nxt;
    answer_r <= answer_nxt;
    first_r  <= first_nxt;
    words_r  <= words_nxt;
    oor_r    <= oor_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_answer       = answer_r;
  assign out_first_set    = first_r;
  assign out_words_in_use = words_r;
  assign out_out_of_range = oor_r;

endmodule
